// ----- src/ddrw_pkg.sv -----
// types and constants shared by the decimal digit register writer
package ddrw_pkg;

    localparam int VALUE_W = 32;
    localparam int CODE_W  = 4;
    localparam int ADDR_W  = 3;

    typedef logic [CODE_W-1:0] t_code;

    localparam t_code CODE_DASH  = 4'd10;
    localparam t_code CODE_BLANK = 4'd15;

    // floor(x / 10) == (x * RECIP_10) >> RECIP_SHIFT for any 32-bit x
    localparam logic [31:0] RECIP_10    = 32'hCCCC_CCCD;
    localparam int          RECIP_SHIFT = 35;

    typedef struct packed {
        logic vld;
        logic ovr;
    } t_ctl;

endpackage

// ----- src/ddrw_digit_stage.sv -----
// one pipeline stage that peels off a decimal digit by reciprocal multiply
module ddrw_digit_stage
    import ddrw_pkg::*;
#(
    parameter int VAL_W       = 27,
    parameter int DIGIT_COUNT = 4,
    parameter int IDX         = 0
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_en,
    input  t_ctl                              i_ctl,
    input  logic [VAL_W-1:0]                  i_rest,
    input  logic [DIGIT_COUNT-1:0][CODE_W-1:0] i_codes,
    output t_ctl                              o_ctl,
    output logic [VAL_W-1:0]                  o_rest,
    output logic [DIGIT_COUNT-1:0][CODE_W-1:0] o_codes
);

    logic [63:0]                        w_prod;
    logic [VAL_W-1:0]                   w_quot;
    logic [VAL_W-1:0]                   w_quot10;
    logic [VAL_W-1:0]                   w_rem;
    t_code                              w_code;
    logic [DIGIT_COUNT-1:0][CODE_W-1:0] n_codes;

    t_ctl                               r_ctl;
    logic [VAL_W-1:0]                   r_rest;
    logic [DIGIT_COUNT-1:0][CODE_W-1:0] r_codes;

    always_comb begin
        w_prod   = 64'(32'(i_rest)) * 64'(RECIP_10);
        w_quot   = VAL_W'(w_prod >> RECIP_SHIFT);
        w_quot10 = VAL_W'({w_quot, 3'b000}) + VAL_W'({w_quot, 1'b0});
        w_rem    = i_rest - w_quot10;
        if (i_ctl.ovr) begin
            w_code = CODE_DASH;
        end else if ((IDX != 0) && (i_rest == '0)) begin
            // leading zero above the units
            w_code = CODE_BLANK;
        end else begin
            w_code = w_rem[CODE_W-1:0];
        end
        n_codes      = i_codes;
        n_codes[IDX] = w_code;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (i_en) begin
            r_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rest  <= w_quot;
            r_codes <= n_codes;
        end
    end

    assign o_ctl   = r_ctl;
    assign o_rest  = r_rest;
    assign o_codes = r_codes;

endmodule

// ----- src/decimal_digit_register_writer.sv -----
// decimal digit register writer: value in, one register write per digit out
//
// input channel: i_value with i_valid / o_ready, one value per transfer.
// output channel: o_digit_address, o_digit_code, o_last_write with
// o_valid / i_ready. each value gives DIGIT_COUNT writes, units first
// (address 1), o_last_write high on the most significant digit.
// codes 0-9 are digits, 15 blanks leading zeros, and a value above
// 10^DIGIT_COUNT - 1 shows 10 (dash) in every digit.
// the first write of a value passes the entry register, the range check
// stage, every digit stage and the serializer register before it is shown.
// the output channel moves one digit write per cycle while i_ready is
// high and sets the sustained rate; the pipeline itself (an entry
// register, a range check stage and one divide-by-ten stage per digit)
// takes a new value every cycle while it has room.
// reset clears all valid bits; no write is pending afterwards.
// when the receiver stalls, the current write holds and the pipeline
// freezes as a whole once its last stage waits for the serializer;
// o_ready falls and nothing is dropped or repeated.
module decimal_digit_register_writer
    import ddrw_pkg::*;
#(
    parameter int DIGIT_COUNT = 4
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [VALUE_W-1:0]  i_value,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [ADDR_W-1:0]   o_digit_address,
    output logic [CODE_W-1:0]   o_digit_code,
    output logic                o_last_write
);

    localparam logic [VALUE_W-1:0] LIMIT = VALUE_W'(10 ** DIGIT_COUNT - 1);
    localparam int VAL_W = $clog2(10 ** DIGIT_COUNT);
    localparam int CNT_W = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;

    logic                w_en;
    logic                w_load;
    logic                w_can_load;
    logic                w_ser_last;

    // entry stage
    logic                r_a_vld;
    logic [VALUE_W-1:0]  r_a_val;

    // range check stage feeds the digit stages
    t_ctl                               w_ctl   [DIGIT_COUNT+1];
    logic [VAL_W-1:0]                   w_rest  [DIGIT_COUNT+1];
    logic [DIGIT_COUNT-1:0][CODE_W-1:0] w_codes [DIGIT_COUNT+1];

    t_ctl                r_b_ctl;
    logic [VAL_W-1:0]    r_b_rest;

    // output serializer
    logic                               r_ser_vld;
    logic [CNT_W-1:0]                   r_ser_idx;
    logic [DIGIT_COUNT-1:0][CODE_W-1:0] r_ser_codes;

    assign w_ser_last = (r_ser_idx == CNT_W'(DIGIT_COUNT - 1));
    assign w_can_load = !r_ser_vld || (i_ready && w_ser_last);
    assign w_en       = !(w_ctl[DIGIT_COUNT].vld && !w_can_load);
    assign w_load     = w_en && w_ctl[DIGIT_COUNT].vld;
    assign o_ready    = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_ctl <= '0;
        end else if (w_en) begin
            r_a_vld     <= i_valid;
            r_b_ctl.vld <= r_a_vld;
            r_b_ctl.ovr <= (r_a_val > LIMIT);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_a_val  <= i_value;
            r_b_rest <= r_a_val[VAL_W-1:0];
        end
    end

    assign w_ctl[0]   = r_b_ctl;
    assign w_rest[0]  = r_b_rest;
    assign w_codes[0] = '0;

    for (genvar k = 0; k < DIGIT_COUNT; k++) begin : g_digit
        ddrw_digit_stage #(
            .VAL_W       (VAL_W),
            .DIGIT_COUNT (DIGIT_COUNT),
            .IDX         (k)
        ) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_ctl   (w_ctl[k]),
            .i_rest  (w_rest[k]),
            .i_codes (w_codes[k]),
            .o_ctl   (w_ctl[k+1]),
            .o_rest  (w_rest[k+1]),
            .o_codes (w_codes[k+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ser_vld <= 1'b0;
            r_ser_idx <= '0;
        end else if (w_load) begin
            r_ser_vld <= 1'b1;
            r_ser_idx <= '0;
        end else if (r_ser_vld && i_ready) begin
            if (w_ser_last) begin
                r_ser_vld <= 1'b0;
            end else begin
                r_ser_idx <= r_ser_idx + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_ser_codes <= w_codes[DIGIT_COUNT];
        end
    end

    // address wraps to 0 for the eighth digit in a 3-bit field
    assign o_valid         = r_ser_vld;
    assign o_digit_address = ADDR_W'(r_ser_idx) + ADDR_W'(1);
    assign o_digit_code    = r_ser_codes[r_ser_idx];
    assign o_last_write    = w_ser_last;

`ifndef ASSERT_OFF
    logic w_all_dash;

    always_comb begin
        w_all_dash = 1'b1;
        for (int j = 0; j < DIGIT_COUNT; j++) begin
            if (w_codes[DIGIT_COUNT][j] != CODE_DASH) begin
                w_all_dash = 1'b0;
            end
        end
    end

    a_ovr_dash : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_ctl[DIGIT_COUNT].vld && w_ctl[DIGIT_COUNT].ovr) |-> w_all_dash)
        else $error("overflow value without all dashes");

    a_units_digit : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_ctl[DIGIT_COUNT].vld && !w_ctl[DIGIT_COUNT].ovr)
        |-> (w_codes[DIGIT_COUNT][0] <= 4'd9))
        else $error("units digit out of decimal range");

    a_ser_done : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_ready && o_last_write && !w_load) |=> !o_valid)
        else $error("serializer kept writing past the last digit");

    a_no_overrun : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(r_ser_idx)))
        else $error("stalled digit write lost its place");
`endif

endmodule
